[sv/ehw_pkg.sv]
`default_nettype none

package ehw_pkg;

    // fixed field widths
    localparam int PIX_W = 8;
    localparam int POS_W = 10;
    localparam int CFG_W = 11;

    // default geometry limits and register reset value
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int RESET_DIM      = 1024;

    // pixel codes
    localparam logic [PIX_W-1:0] WEAK_CODE   = 8'd25;
    localparam logic [PIX_W-1:0] STRONG_CODE = 8'd255;
    localparam logic [PIX_W-1:0] NONE_CODE   = 8'd0;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    // one result item
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             run_last;
        logic             frame_last;
    } t_result;

    // the two stored rows at one column
    typedef struct packed {
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] newer;
    } t_line_pair;

    // per-request position flags
    typedef struct packed {
        logic row_end;
        logic last_row;
        logic interior;
        logic emit_centre;
        logic emit_edge;
    } t_item_ctl;

endpackage

`default_nettype wire

[sv/ehw_line_mem.sv]
`default_nettype none

module ehw_line_mem #(
    parameter int MAX_WIDTH = ehw_pkg::DEF_MAX_WIDTH,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_rd_en,
    input  wire logic [COL_W-1:0]   i_rd_addr,
    output ehw_pkg::t_line_pair     o_rd_data,
    input  wire logic               i_wr_en,
    input  wire logic [COL_W-1:0]   i_wr_addr,
    input  wire ehw_pkg::t_line_pair i_wr_data
);
    import ehw_pkg::*;

    t_line_pair r_mem [0:MAX_WIDTH-1];
    t_line_pair r_mem_q;
    t_line_pair r_fwd_data;
    logic       r_fwd_hit;

    // line storage, one read and one write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_mem_q <= r_mem[i_rd_addr];
        end
    end

    // bypass when a read meets a write to the same column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_mem_q;

endmodule

`default_nettype wire

[sv/ehw_window.sv]
`default_nettype none

module ehw_window #(
    parameter int ROW_W = 10,
    parameter int COL_W = 10
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_adv,
    input  wire logic [ehw_pkg::PIX_W-1:0]   i_pix,
    input  wire ehw_pkg::t_line_pair         i_line,
    input  wire ehw_pkg::t_item_ctl          i_ctl,
    input  wire logic [ROW_W-1:0]            i_row,
    input  wire logic [COL_W-1:0]            i_col,
    output ehw_pkg::t_result [2:0]           o_slots,
    output logic [1:0]                       o_count
);
    import ehw_pkg::*;

    logic [PIX_W-1:0] r_win [0:2][0:2];
    logic [PIX_W-1:0] n_win [0:2][0:2];
    logic             strong_hit;
    logic [PIX_W-1:0] centre;
    logic [PIX_W-1:0] centre_pix;
    logic [ROW_W-1:0] row_m1;
    logic [COL_W-1:0] col_m1;
    t_result          res_c;
    t_result          res_e;
    t_result          res_l;
    t_result [2:0]    slots;
    logic [1:0]       count;

    // shift the window left and bring in the new column
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = r_win[i][1];
            n_win[i][1] = r_win[i][2];
        end
        n_win[0][2] = i_line.older;
        n_win[1][2] = i_line.newer;
        n_win[2][2] = i_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (i_adv) begin
            r_win <= n_win;
        end
    end

    // any strong code in the neighbourhood
    always_comb begin
        strong_hit = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (n_win[i][j] == STRONG_CODE) begin
                    strong_hit = 1'b1;
                end
            end
        end
    end

    // weak centre is promoted or dropped
    assign centre = r_win[1][2];
    always_comb begin
        centre_pix = centre;
        if (i_ctl.interior && centre == WEAK_CODE) begin
            centre_pix = strong_hit ? STRONG_CODE : NONE_CODE;
        end
    end

    assign row_m1 = i_row - 1'b1;
    assign col_m1 = i_col - 1'b1;

    // candidate results
    always_comb begin
        res_c.pix        = centre_pix;
        res_c.row        = POS_W'(row_m1);
        res_c.col        = POS_W'(col_m1);
        res_c.run_last   = 1'b0;
        res_c.frame_last = 1'b0;

        res_e.pix        = i_line.newer;
        res_e.row        = POS_W'(row_m1);
        res_e.col        = POS_W'(i_col);
        res_e.run_last   = 1'b0;
        res_e.frame_last = 1'b0;

        res_l.pix        = i_pix;
        res_l.row        = POS_W'(i_row);
        res_l.col        = POS_W'(i_col);
        res_l.run_last   = 1'b0;
        res_l.frame_last = i_ctl.row_end;
    end

    // pack present results in order and mark the last one
    always_comb begin
        slots[2] = res_l;
        if (i_ctl.emit_centre) begin
            slots[0] = res_c;
            slots[1] = i_ctl.emit_edge ? res_e : res_l;
        end else begin
            slots[0] = i_ctl.emit_edge ? res_e : res_l;
            slots[1] = res_l;
        end
        count = 2'(i_ctl.emit_centre) + 2'(i_ctl.emit_edge) + 2'(i_ctl.last_row);
        for (int k = 0; k < 3; k++) begin
            slots[k].run_last = (count == 2'(k + 1));
        end
    end

    assign o_slots = slots;
    assign o_count = count;

endmodule

`default_nettype wire

[sv/ehw_out_buf.sv]
`default_nettype none

module ehw_out_buf (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire ehw_pkg::t_result [2:0]      i_slots,
    input  wire logic [1:0]                  i_count,
    output logic                             o_can_load,
    input  wire logic                        i_ready,
    output logic                             o_valid,
    output ehw_pkg::t_result                 o_head
);
    import ehw_pkg::*;

    t_result [2:0] r_slots;
    logic [1:0]    r_count;
    logic [1:0]    n_count;
    logic          pop;

    assign o_valid    = (r_count != 2'd0);
    assign pop        = o_valid && i_ready;
    assign o_can_load = (r_count == 2'd0) || (r_count == 2'd1 && pop);
    assign o_head     = r_slots[0];

    // fill count of the result register
    always_comb begin
        n_count = r_count;
        if (i_load) begin
            n_count = i_count;
        end else if (pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    // result slots, shifted towards the head as results leave
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slots <= i_slots;
        end else if (pop) begin
            r_slots[0] <= r_slots[1];
            r_slots[1] <= r_slots[2];
        end
    end

endmodule

`default_nettype wire

[sv/edge_hysteresis_window.sv]
`default_nettype none

// Streaming single-pass hysteresis over an edge map, one 8-bit pixel code per
// request in raster order. An interior pixel holding the weak code 25 leaves as
// 255 when any of its eight input neighbours is 255 and as 0 otherwise; all
// other pixels, border rows and columns included, leave unchanged. Results
// trail the input by one row and one column, each tagged with its own row and
// column; a row end also releases the right-hand pixel of the row above, and
// the last row leaves as it arrives, so one request yields zero to three
// results. The two previous rows live in one line memory of MAX_WIDTH words
// (read at acceptance, written back as the request leaves the read stage, with
// a bypass for a read of the column being written), so no clearing pass is
// needed after reset. One request is taken every cycle while each yields at
// most one result and results are taken; the three-slot result register
// takes a new request's results only once it is empty or its last result is
// leaving, so a request with two or three results holds later requests back.
// A request passes the read stage, then the result register. frame_width and
// frame_height are clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT.

module edge_hysteresis_window #(
    parameter int MAX_WIDTH  = ehw_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ehw_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // pixel requests
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [ehw_pkg::PIX_W-1:0]   i_pixel_in,
    // results
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [ehw_pkg::PIX_W-1:0]        o_pixel_out,
    output logic [ehw_pkg::POS_W-1:0]        o_out_row,
    output logic [ehw_pkg::POS_W-1:0]        o_out_col,
    output logic                             o_run_last,
    output logic                             o_frame_last,
    // configuration writes
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic                        i_cfg_index,
    input  wire logic [ehw_pkg::CFG_W-1:0]   i_cfg_data
);
    import ehw_pkg::*;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int WDIM_W  = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
    localparam int RST_W   = (RESET_DIM > MAX_WIDTH) ? MAX_WIDTH : RESET_DIM;
    localparam int RST_H   = (RESET_DIM > MAX_HEIGHT) ? MAX_HEIGHT : RESET_DIM;

    logic [WDIM_W-1:0] r_width;
    logic [HDIM_W-1:0] r_height;
    logic [WDIM_W-1:0] cfg_w;
    logic [HDIM_W-1:0] cfg_h;

    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [WDIM_W-1:0] col_p1;
    logic [HDIM_W-1:0] row_p1;
    t_item_ctl         ctl;
    logic              accept;

    logic              r_s1_valid;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [ROW_W-1:0]  r_s1_row;
    logic [COL_W-1:0]  r_s1_col;
    t_item_ctl         r_s1_ctl;
    logic              s1_adv;

    t_line_pair        line_rd;
    t_line_pair        line_wr;
    t_result [2:0]     res_slots;
    logic [1:0]        res_count;
    logic              can_load;
    t_result           head;

    // configuration: clamp on write
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_w = WDIM_W'(1);
            cfg_h = HDIM_W'(1);
        end else begin
            cfg_w = (int'(i_cfg_data) > MAX_WIDTH)  ? WDIM_W'(MAX_WIDTH)  : WDIM_W'(i_cfg_data);
            cfg_h = (int'(i_cfg_data) > MAX_HEIGHT) ? HDIM_W'(MAX_HEIGHT) : HDIM_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WDIM_W'(RST_W);
            r_height <= HDIM_W'(RST_H);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_width  <= cfg_w;
                CFG_FRAME_HEIGHT: r_height <= cfg_h;
            endcase
        end
    end

    // position flags of the incoming request
    assign col_p1 = WDIM_W'(r_col) + 1'b1;
    assign row_p1 = HDIM_W'(r_row) + 1'b1;

    always_comb begin
        ctl.row_end     = (col_p1 >= r_width);
        ctl.last_row    = (row_p1 >= r_height);
        ctl.emit_centre = (r_row != '0) && (r_col != '0);
        ctl.emit_edge   = (r_row != '0) && ctl.row_end;
        ctl.interior    = (r_row >= ROW_W'(2)) && (row_p1 <= r_height)
                       && (r_col >= COL_W'(2)) && (col_p1 <= r_width);
    end

    // request handshake
    assign s1_adv  = r_s1_valid && can_load;
    assign o_ready = !r_s1_valid || can_load;
    assign accept  = i_valid && o_ready;

    // raster position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (ctl.row_end) begin
                r_col <= '0;
                r_row <= ctl.last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // stage after the line memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pix <= i_pixel_in;
            r_s1_row <= r_row;
            r_s1_col <= r_col;
            r_s1_ctl <= ctl;
        end
    end

    // rows move down one place in the line memory
    assign line_wr.older = line_rd.newer;
    assign line_wr.newer = r_s1_pix;

    ehw_line_mem #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (r_col),
        .o_rd_data (line_rd),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_col),
        .i_wr_data (line_wr)
    );

    ehw_window #(
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (s1_adv),
        .i_pix   (r_s1_pix),
        .i_line  (line_rd),
        .i_ctl   (r_s1_ctl),
        .i_row   (r_s1_row),
        .i_col   (r_s1_col),
        .o_slots (res_slots),
        .o_count (res_count)
    );

    ehw_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s1_adv),
        .i_slots    (res_slots),
        .i_count    (res_count),
        .o_can_load (can_load),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_head     (head)
    );

    assign o_pixel_out  = head.pix;
    assign o_out_row    = head.row;
    assign o_out_col    = head.col;
    assign o_run_last   = head.run_last;
    assign o_frame_last = head.frame_last;

endmodule

`default_nettype wire
